// ===== rtl/core/bounded_stack_with_indexed_access_core_macros.svh =====
// assertion macros for the indexed stack core
// no dependencies; included by files that carry concurrent checks
`ifndef BOUNDED_STACK_WITH_INDEXED_ACCESS_CORE_MACROS_SVH
`define BOUNDED_STACK_WITH_INDEXED_ACCESS_CORE_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define BSIA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsia check failed");
// antecedent implies consequent in the next cycle
`define BSIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsia check failed");
`else
`define BSIA_ASSERT_SAME(label, clk, rst, ante, cons)
`define BSIA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/bsia_pkg.sv =====
// shared types and constants of the indexed stack core
// no dependencies; used by the interfaces, the store and the top level
package bsia_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LVL_W  = $clog2(DEPTH + 1);
  localparam int CFG_W  = 7;
  localparam int POS_W  = 8;
  localparam int CMD_W  = 3;
  localparam int ST_W   = 2;
  localparam int CMP_W  = (POS_W > LVL_W) ? ((POS_W > CFG_W) ? POS_W : CFG_W)
                                          : ((LVL_W > CFG_W) ? LVL_W : CFG_W);
  localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(64);

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_POP  = 3'd1,
    CMD_PEEK = 3'd2,
    CMD_RD   = 3'd3,
    CMD_WR   = 3'd4
  } cmd_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // access request to the entry store
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

endpackage

// ===== rtl/core/bsia_ifs.sv =====
// channel interfaces of the indexed stack core: request, result, limit write
// depends on bsia_pkg for field widths
interface bsia_req_if;
  logic                        valid;
  logic                        ready;
  logic [bsia_pkg::CMD_W-1:0]  command;
  logic [bsia_pkg::DATA_W-1:0] value;
  logic [bsia_pkg::POS_W-1:0]  position;
  modport source (output valid, command, value, position, input ready);
  modport sink (input valid, command, value, position, output ready);
endinterface

interface bsia_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bsia_pkg::DATA_W-1:0] read_value;
  logic [bsia_pkg::ST_W-1:0]   status;
  logic [bsia_pkg::LVL_W-1:0]  level;
  logic                        is_empty;
  logic                        is_full;
  modport source (output valid, read_value, status, level, is_empty, is_full,
                  input ready);
  modport sink (input valid, read_value, status, level, is_empty, is_full,
                output ready);
endinterface

interface bsia_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bsia_pkg::CFG_W-1:0] stack_limit;
  modport source (output valid, stack_limit, input ready);
  modport sink (input valid, stack_limit, output ready);
endinterface

// ===== rtl/core/bsia_store.sv =====
// entry store: single-port-write, registered-read memory with per-entry valid bits
// depends on bsia_pkg; unwritten entries read as zero after reset
module bsia_store (
  input  logic                        clk,
  input  logic                        rst,
  input  bsia_pkg::store_req_t        acc,
  output logic [bsia_pkg::DATA_W-1:0] rd_data
);
  import bsia_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  written;
  logic [DATA_W-1:0] rdata;
  logic              rvalid;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (acc.wr_en) begin
      mem[acc.wr_addr] <= acc.wr_data;
    end
    if (acc.rd_en) begin
      rdata <= mem[acc.rd_addr];
    end
  end

  // written flags, cleared at reset so the store reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvalid  <= 1'b0;
    end else begin
      if (acc.wr_en) begin
        written[acc.wr_addr] <= 1'b1;
      end
      if (acc.rd_en) begin
        rvalid <= written[acc.rd_addr];
      end
    end
  end

  assign rd_data = rvalid ? rdata : '0;

endmodule

// ===== rtl/core/bounded_stack_with_indexed_access_core.sv =====
// top level of the bounded stack with indexed access
// depends on bsia_pkg, bsia_ifs, bsia_store and the assertion macro header
`include "bounded_stack_with_indexed_access_core_macros.svh"
// Usage
//   req : command requests (command, value, position), valid/ready
//   rsp : one result per request (read_value, status, level, is_empty,
//         is_full), valid/ready
//   cfg : writes the stack_limit register; always ready, write only while
//         no request is in flight
// Timing
//   a request is decoded in its accept cycle: level and memory write are
//   updated there and the memory read is issued. The result then moves from
//   the read stage into the output register, which drives rsp.valid. One
//   request per cycle is sustained while rsp is not held off; the registered
//   memory read forms the read stage, the level register the per-cycle decode.
// Reset
//   level goes to 0, stack_limit to 64, all entries read as zero (per-entry
//   written flags, no clearing pass), no result pending.
// Stall
//   when rsp is held off, the result stays in the output register, the read
//   stage keeps one more request and then req.ready drops.
module bounded_stack_with_indexed_access_core (
  input logic        clk,
  input logic        rst,
  bsia_req_if.sink   req,
  bsia_rsp_if.source rsp,
  bsia_cfg_if.sink   cfg
);
  import bsia_pkg::*;

  logic [CFG_W-1:0]  stack_limit;
  logic [LVL_W-1:0]  level;
  logic [LVL_W-1:0]  level_next;
  logic [LVL_W-1:0]  lim;
  logic              req_fire;
  logic              s1_adv;
  store_req_t        acc;
  logic [DATA_W-1:0] rd_data;
  status_t           st_next;
  logic              rd_next;

  // read stage
  logic              s1_valid;
  status_t           s1_status;
  logic [LVL_W-1:0]  s1_level;
  logic              s1_full;
  logic              s1_rd;

  // output register
  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  status_t           out_status;
  logic [LVL_W-1:0]  out_level;
  logic              out_empty;
  logic              out_full;

  // limit register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      stack_limit <= cfg.stack_limit;
    end
  end

  // effective limit clamped to 1..DEPTH
  always_comb begin
    if (stack_limit == '0) begin
      lim = LVL_W'(1);
    end else if (CMP_W'(stack_limit) > CMP_W'(DEPTH)) begin
      lim = LVL_W'(DEPTH);
    end else begin
      lim = LVL_W'(stack_limit);
    end
  end

  // handshakes
  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign req_fire  = req.valid && req.ready;

  // command decode: level update, memory access, status
  always_comb begin
    level_next  = level;
    st_next     = ST_OK;
    rd_next     = 1'b0;
    acc.wr_en   = 1'b0;
    acc.wr_addr = ADDR_W'(level);
    acc.wr_data = req.value;
    acc.rd_en   = 1'b0;
    acc.rd_addr = ADDR_W'(level - LVL_W'(1));
    case (req.command)
      CMD_PUSH: begin
        if (level >= lim) begin
          st_next = ST_FULL;
        end else begin
          acc.wr_en  = req_fire;
          level_next = level + LVL_W'(1);
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (level == '0) begin
          st_next = ST_EMPTY;
        end else begin
          acc.rd_en = req_fire;
          rd_next   = 1'b1;
          if (req.command == CMD_POP) begin
            level_next = level - LVL_W'(1);
          end
        end
      end
      CMD_RD, CMD_WR: begin
        acc.wr_addr = ADDR_W'(req.position);
        acc.rd_addr = ADDR_W'(req.position);
        if (CMP_W'(req.position) >= CMP_W'(lim)) begin
          st_next = ST_RANGE;
        end else begin
          level_next = LVL_W'(req.position) + LVL_W'(1);
          if (req.command == CMD_RD) begin
            acc.rd_en = req_fire;
            rd_next   = 1'b1;
          end else begin
            acc.wr_en = req_fire;
          end
        end
      end
      default: begin
        level_next = level;
      end
    endcase
  end

  bsia_store u_store (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .rd_data (rd_data)
  );

  // level register
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (req_fire) begin
      level <= level_next;
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_status <= st_next;
      s1_level  <= level_next;
      s1_full   <= (level_next >= lim);
      s1_rd     <= rd_next;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value  <= s1_rd ? rd_data : '0;
      out_status <= s1_status;
      out_level  <= s1_level;
      out_empty  <= (s1_level == '0);
      out_full   <= s1_full;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.status     = out_status;
  assign rsp.level      = out_level;
  assign rsp.is_empty   = out_empty;
  assign rsp.is_full    = out_full;

  // checks
  `BSIA_ASSERT_SAME(a_level_bound, clk, rst, 1'b1, level <= LVL_W'(DEPTH))
  `BSIA_ASSERT_SAME(a_no_overrun, clk, rst, req_fire, !s1_valid || s1_adv)
  `BSIA_ASSERT_SAME(a_full_flag, clk, rst, rsp.valid && rsp.status == ST_FULL,
    rsp.is_full && rsp.read_value == '0)
  `BSIA_ASSERT_SAME(a_empty_flag, clk, rst, rsp.valid && rsp.status == ST_EMPTY,
    rsp.is_empty && rsp.read_value == '0)
  `BSIA_ASSERT_NEXT(a_result_follows, clk, rst, s1_valid && s1_adv, out_valid)

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for the bounded stack with indexed access
// depends on bsia_pkg, bsia_ifs and bounded_stack_with_indexed_access_core
module tb;
  import bsia_pkg::*;

  // command codes with no operation behind them
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_REQUESTS = 200;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    status_t           status;
    logic [LVL_W-1:0]  level;
    logic              is_empty;
    logic              is_full;
  } stack_result_t;

  typedef enum logic {ROW_REQ, ROW_LIMIT} row_kind_t;

  // one directed row: a request, or a limit write carried in value
  typedef struct packed {
    row_kind_t         kind;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
    logic              has_exp;
    stack_result_t     exp;
  } stim_row_t;

  localparam stack_result_t NO_RESULT = '0;
  localparam int NUM_ROWS = 28;

  // directed rows, limit is 64 out of reset
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_REQ, CMD_POP, 32'h0, 8'd0, 1'b1, '{32'h0, ST_EMPTY, 7'd0, 1'b1, 1'b0}},
    '{ROW_REQ, CMD_PEEK, 32'h0, 8'd0, 1'b1, '{32'h0, ST_EMPTY, 7'd0, 1'b1, 1'b0}},
    '{ROW_REQ, CMD_PUSH, 32'hFFFF_FFFF, 8'd0, 1'b1, '{32'h0, ST_OK, 7'd1, 1'b0, 1'b0}},
    '{ROW_REQ, CMD_PEEK, 32'h0, 8'd0, 1'b1, '{32'hFFFF_FFFF, ST_OK, 7'd1, 1'b0, 1'b0}},
    '{ROW_REQ, CMD_RD, 32'h0, 8'd255, 1'b1, '{32'h0, ST_RANGE, 7'd1, 1'b0, 1'b0}},
    '{ROW_REQ, CMD_WR, 32'hDEAD_BEEF, 8'd64, 1'b1, '{32'h0, ST_RANGE, 7'd1, 1'b0, 1'b0}},
    '{ROW_REQ, CMD_WR, 32'hA5A5_A5A5, 8'd63, 1'b1, '{32'h0, ST_OK, 7'd64, 1'b0, 1'b1}},
    '{ROW_REQ, CMD_PUSH, 32'h1234_5678, 8'd0, 1'b1, '{32'h0, ST_FULL, 7'd64, 1'b0, 1'b1}},
    '{ROW_REQ, CMD_RD, 32'h0, 8'd63, 1'b1, '{32'hA5A5_A5A5, ST_OK, 7'd64, 1'b0, 1'b1}},
    '{ROW_REQ, CMD_RD, 32'h0, 8'd10, 1'b1, '{32'h0, ST_OK, 7'd11, 1'b0, 1'b0}},
    '{ROW_REQ, CMD_POP, 32'h0, 8'd0, 1'b0, NO_RESULT},
    '{ROW_REQ, CMD_UNUSED_LO, 32'hFFFF_FFFF, 8'd255, 1'b0, NO_RESULT},
    '{ROW_REQ, CMD_UNUSED_HI, 32'h5555_AAAA, 8'd3, 1'b0, NO_RESULT},
    '{ROW_REQ, CMD_WR, 32'h5A5A_5A5A, 8'd0, 1'b0, NO_RESULT},
    '{ROW_REQ, CMD_POP, 32'h0, 8'd0, 1'b1, '{32'h5A5A_5A5A, ST_OK, 7'd0, 1'b1, 1'b0}},
    '{ROW_REQ, CMD_RD, 32'h0, 8'd0, 1'b0, NO_RESULT},
    '{ROW_REQ, CMD_PUSH, 32'h0, 8'd0, 1'b0, NO_RESULT},
    // limit of one, lowered below the level
    '{ROW_LIMIT, CMD_PUSH, 32'd1, 8'd0, 1'b0, NO_RESULT},
    '{ROW_REQ, CMD_PUSH, 32'h0, 8'd0, 1'b1, '{32'h0, ST_FULL, 7'd2, 1'b0, 1'b1}},
    '{ROW_REQ, CMD_POP, 32'h0, 8'd0, 1'b0, NO_RESULT},
    '{ROW_REQ, CMD_RD, 32'h0, 8'd1, 1'b1, '{32'h0, ST_RANGE, 7'd1, 1'b0, 1'b1}},
    // zero limit acts as one
    '{ROW_LIMIT, CMD_PUSH, 32'd0, 8'd0, 1'b0, NO_RESULT},
    '{ROW_REQ, CMD_WR, 32'h0F0F_0F0F, 8'd0, 1'b1, '{32'h0, ST_OK, 7'd1, 1'b0, 1'b1}},
    '{ROW_REQ, CMD_RD, 32'h0, 8'd1, 1'b1, '{32'h0, ST_RANGE, 7'd1, 1'b0, 1'b1}},
    // oversized limit acts as the full depth
    '{ROW_LIMIT, CMD_PUSH, 32'd127, 8'd0, 1'b0, NO_RESULT},
    '{ROW_REQ, CMD_WR, 32'h0000_0001, 8'd63, 1'b1, '{32'h0, ST_OK, 7'd64, 1'b0, 1'b1}},
    '{ROW_REQ, CMD_RD, 32'h0, 8'd64, 1'b1, '{32'h0, ST_RANGE, 7'd64, 1'b0, 1'b1}},
    '{ROW_REQ, CMD_PEEK, 32'h0, 8'd0, 1'b0, NO_RESULT}
  };

  logic clk;
  logic rst;

  bsia_req_if req_ch ();
  bsia_rsp_if rsp_ch ();
  bsia_cfg_if cfg_ch ();

  bounded_stack_with_indexed_access_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source),
    .cfg (cfg_ch.sink)
  );

  // predicted stack contents, level and limit register
  logic [DATA_W-1:0] pred_entries [DEPTH];
  int                pred_level;
  logic [CFG_W-1:0]  pred_limit;

  stack_result_t expected_results [$];
  int            mismatch_count;
  int            n_requests;
  int            n_limit_writes;
  int            status_seen [4];
  bit            calm;
  int            sink_hold;
  int            stall_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int active_limit();
    int lim;
    lim = pred_limit;
    if (lim < 1) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    return lim;
  endfunction

  // apply one request to the predicted stack and return its result
  function automatic stack_result_t predict_stack_op(input logic [CMD_W-1:0] cmd,
                                                     input logic [DATA_W-1:0] val,
                                                     input logic [POS_W-1:0] pos);
    stack_result_t res;
    int lim;
    lim = active_limit();
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (pred_level >= lim) begin
          res.status = ST_FULL;
        end else begin
          pred_entries[pred_level] = val;
          pred_level++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (pred_level == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.read_value = pred_entries[pred_level-1];
          if (cmd == CMD_POP) pred_level--;
        end
      end
      CMD_RD, CMD_WR: begin
        if (int'(pos) >= lim) begin
          res.status = ST_RANGE;
        end else begin
          pred_level = int'(pos) + 1;
          if (cmd == CMD_RD) res.read_value = pred_entries[pos];
          else pred_entries[pos] = val;
        end
      end
      default: ;
    endcase
    res.level    = pred_level[LVL_W-1:0];
    res.is_empty = (pred_level == 0);
    res.is_full  = (pred_level >= lim);
    return res;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
                               input logic [POS_W-1:0] pos, input bit has_fixed,
                               input stack_result_t fixed);
    int gap;
    stack_result_t predicted;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.command  <= cmd;
    req_ch.value    <= val;
    req_ch.position <= pos;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_stack_op(cmd, val, pos);
    status_seen[predicted.status]++;
    expected_results.push_back(has_fixed ? fixed : predicted);
    n_requests++;
  endtask

  // hold requests back until every result is in
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] lim);
    drain_results();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.stack_limit <= lim;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    pred_limit = lim;
    n_limit_writes++;
  endtask

  task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // result side: random stalls, compare each result with the oldest prediction
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending, read_value %0h status %0d level %0d",
                 $time, rsp_ch.read_value, rsp_ch.status, rsp_ch.level);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("read_value", want.read_value, rsp_ch.read_value);
        check_field("status", want.status, rsp_ch.status);
        check_field("level", want.level, rsp_ch.level);
        check_field("is_empty", want.is_empty, rsp_ch.is_empty);
        check_field("is_full", want.is_full, rsp_ch.is_full);
      end
    end
    if (sink_hold > 0) begin
      rsp_ch.ready <= 1'b0;
      sink_hold--;
    end else begin
      rsp_ch.ready <= 1'b1;
      sink_hold = calm ? 0 : pick_gap();
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [CFG_W-1:0] lim;
    int push_w;
    int r;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_PUSH;
    req_ch.value = '0;
    req_ch.position = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.stack_limit = LIMIT_RESET;
    for (int i = 0; i < DEPTH; i++) pred_entries[i] = '0;
    pred_level = 0;
    pred_limit = LIMIT_RESET;
    mismatch_count = 0;
    n_requests = 0;
    n_limit_writes = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    calm = 1'b0;
    sink_hold = 0;
    stall_cycles = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_LIMIT) write_limit(row.value[CFG_W-1:0]);
      else issue_request(row.cmd, row.value, row.position, row.has_exp, row.exp);
    end

    // random phases, each under its own limit
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: lim = LIMIT_RESET;
        1: lim = CFG_W'(1);
        2: lim = '0;
        3: lim = '1;
        default: lim = (phase % 2) ? CFG_W'($urandom_range(0, 127))
                                   : CFG_W'($urandom_range(2, 8));
      endcase
      write_limit(lim);
      calm = (phase % 4 == 2);
      push_w = 45;
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        // shift the push weight so the level swings between empty and full
        if (k % 32 == 0) begin
          case ($urandom_range(0, 2))
            0: push_w = 20;
            1: push_w = 45;
            default: push_w = 70;
          endcase
        end
        r = $urandom_range(0, 99);
        if (r < push_w) begin
          cmd = CMD_PUSH;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 35) cmd = CMD_POP;
          else if (r < 50) cmd = CMD_PEEK;
          else if (r < 70) cmd = CMD_RD;
          else if (r < 92) cmd = CMD_WR;
          else cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end
        if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, active_limit() - 1));
        else pos = POS_W'($urandom_range(0, 255));
        issue_request(cmd, $urandom, pos, 1'b0, NO_RESULT);
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("covered %0d requests under %0d limit writes, including zero and oversized limits",
             n_requests, n_limit_writes);
    $display("status mix: ok %0d, full refusals %0d, empty reads %0d, out of range %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_RANGE]);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
